>>> rtl/qel_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadrature edge logger package
// Request kinds and motion codes shared by the logger RTL.
// ----------------------------------------------------------------------------
package qel_pkg;

   typedef enum logic [1:0] {
      REQ_SYNC   = 2'd0,
      REQ_EDGE_A = 2'd1,
      REQ_EDGE_B = 2'd2,
      REQ_READ   = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      MOT_STATIONARY = 2'd0,
      MOT_FORWARD    = 2'd1,
      MOT_BACKWARD   = 2'd2
   } motion_type;

   localparam int unsigned TIME_W = 32;
   localparam int unsigned COUNT_W = 32;

endpackage

>>> rtl/quadrature_edge_logger.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadrature edge logger
// Decodes quadrature encoder events into direction and an odometer count,
// and logs edge-to-edge intervals in a FIFO that is drained by read requests.
// ----------------------------------------------------------------------------
// A response is valid the cycle after acceptance. Throughput: one transaction
// per cycle without a rsp_tready stall; the single response register sets
// this, and the interval FIFO takes one write or one registered read per item.
// Reset: synchronous, active high; clears pin levels, direction, odometer,
// previous timestamp and FIFO pointers. FIFO contents are not cleared.
// ----------------------------------------------------------------------------
module quadrature_edge_logger
   import qel_pkg::*;
#(
   parameter int unsigned LOG_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // level_a, level_b, time_us[31:0], zero pad
   input  logic [1:0]  req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata    // motion[1:0], forward_count[31:0],
                                    // log_valid, log_word[31:0], log_dropped,
                                    // zero pad
);

   localparam int unsigned IDX_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(LOG_DEPTH + 1);
   localparam logic [IDX_W:0]   DEPTH_SUM = (IDX_W + 1)'(LOG_DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(LOG_DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(LOG_DEPTH - 1);

   // Request fields
   req_kind_type      req_kind;
   logic              level_a;
   logic              level_b;
   logic [TIME_W-1:0] time_us;

   // State
   logic               held_a_ff, held_a_in;
   logic               held_b_ff, held_b_in;
   motion_type         motion_ff, motion_in;
   logic [TIME_W-1:0]  prev_time_ff, prev_time_in;
   logic [COUNT_W-1:0] odo_ff, odo_in;
   logic [IDX_W-1:0]   head_ff, head_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;

   // Response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               log_valid_ff, log_valid_in;
   logic               dropped_ff, dropped_in;
   logic [TIME_W-1:0]  rd_word_ff;

   // Interval store
   logic [TIME_W-1:0]  store_mem [LOG_DEPTH];
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [TIME_W-1:0]  wr_data;
   logic               rd_en;

   logic               accept;
   logic               is_edge;
   logic               forward;
   logic               full;
   logic [IDX_W:0]     slot_sum;
   logic [IDX_W-1:0]   slot;
   logic [TIME_W-1:0]  interval;

   assign req_kind = req_kind_type'(req_tuser);
   assign level_a  = req_tdata[0];
   assign level_b  = req_tdata[1];
   assign time_us  = req_tdata[33:2];

   // The response register frees up whenever its transaction is taken.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign is_edge  = (req_kind == REQ_EDGE_A) || (req_kind == REQ_EDGE_B);
   assign full     = (fill_ff == DEPTH_CNT);
   assign interval = time_us - prev_time_ff;
   assign slot_sum = {1'b0, head_ff} + {1'b0, fill_ff[IDX_W-1:0]};
   assign slot     = (slot_sum >= DEPTH_SUM) ? IDX_W'(slot_sum - DEPTH_SUM)
                                             : slot_sum[IDX_W-1:0];

   always_comb begin
      held_a_in    = held_a_ff;
      held_b_in    = held_b_ff;
      motion_in    = motion_ff;
      prev_time_in = prev_time_ff;
      odo_in       = odo_ff;
      head_in      = head_ff;
      fill_in      = fill_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      log_valid_in = log_valid_ff;
      dropped_in   = dropped_ff;
      forward      = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = slot;
      wr_data      = interval;
      rd_en        = 1'b0;
      if (accept) begin
         rsp_valid_in = 1'b1;
         log_valid_in = 1'b0;
         dropped_in   = 1'b0;
         case (req_kind)
            REQ_SYNC: begin
               held_a_in = level_a;
               held_b_in = level_b;
            end
            REQ_EDGE_A: begin
               held_a_in = level_a;
               forward   = (level_a == held_b_ff);
            end
            REQ_EDGE_B: begin
               held_b_in = level_b;
               forward   = (held_a_ff != level_b);
            end
            REQ_READ: begin
               if (fill_ff != '0) begin
                  rd_en        = 1'b1;
                  log_valid_in = 1'b1;
                  head_in      = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
                  fill_in      = fill_ff - 1'b1;
               end
            end
            default: begin
               held_a_in = held_a_ff;
            end
         endcase
         if (is_edge) begin
            motion_in    = forward ? MOT_FORWARD : MOT_BACKWARD;
            odo_in       = forward ? odo_ff + 1'b1 : odo_ff;
            prev_time_in = time_us;
            wr_en        = 1'b1;
            // A full log marks the oldest entry as lost and keeps its fill.
            if (full) begin
               wr_addr    = head_ff;
               wr_data    = '0;
               dropped_in = 1'b1;
            end else begin
               fill_in = fill_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_a_ff    <= 1'b0;
         held_b_ff    <= 1'b0;
         motion_ff    <= MOT_STATIONARY;
         prev_time_ff <= '0;
         odo_ff       <= '0;
         head_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         held_a_ff    <= held_a_in;
         held_b_ff    <= held_b_in;
         motion_ff    <= motion_in;
         prev_time_ff <= prev_time_in;
         odo_ff       <= odo_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      log_valid_ff <= log_valid_in;
      dropped_ff   <= dropped_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_word_ff <= store_mem[head_ff];
      end
   end

   // Direction and odometer registers already hold the values after the
   // transaction in the response register, since state only moves on accept.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000,
                        dropped_ff,
                        log_valid_ff ? rd_word_ff : {TIME_W{1'b0}},
                        log_valid_ff,
                        odo_ff,
                        motion_ff};

endmodule
